// ===== src/rarst_pkg.sv =====
// ----------------------------------------------------------------------------
// rarst_pkg
// Shared types and constants of the range-add / range-sum tree unit.
// ----------------------------------------------------------------------------
package rarst_pkg;

  // Tree geometry
  localparam int unsigned MaxLeaves = 1024;
  localparam int unsigned NodeCount = 4 * MaxLeaves;
  localparam int unsigned NodeAw    = $clog2(NodeCount);
  localparam int unsigned LeafW     = $clog2(MaxLeaves) + 1;
  localparam int unsigned DataW     = 32;

  // Input word
  typedef struct packed {
    logic              func;
    logic [9:0]        left;
    logic [10:0]       right;
    logic signed [31:0] increment;
  } in_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] range_sum;
    logic               bad_range;
  } out_t;

  // One tree node in memory
  typedef struct packed {
    logic [DataW-1:0] total;
    logic [DataW-1:0] pending;
  } node_t;

  // Write data selection
  typedef enum logic [1:0] {
    WR_CLEAR,
    WR_COVER,
    WR_PEND_ZERO,
    WR_SUM
  } wr_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [NodeAw-1:0] addr;
    wr_sel_e           wr_sel;
    logic              use_pend;
    logic              mul_go;
    logic [LeafW-1:0]  len;
    logic              cap_pend;
    logic              cap_tmp;
    logic              acc_clr;
    logic              acc_add;
    logic              load_in;
    logic              res_load;
    logic              res_bad;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pend_nz;
  } stat_t;

endpackage

// ===== src/rarst_datapath.sv =====
// ----------------------------------------------------------------------------
// rarst_datapath
// Node memory, multiplier, accumulator and result register.
// ----------------------------------------------------------------------------
module rarst_datapath (
  input  logic            clk_i,
  input  rarst_pkg::cmd_t cmd_i,
  input  rarst_pkg::in_t  in_data_i,
  output rarst_pkg::stat_t stat_o,
  output rarst_pkg::out_t out_data_o
);

  rarst_pkg::node_t mem_q [rarst_pkg::NodeCount];
  rarst_pkg::node_t rdata_q;
  rarst_pkg::node_t wdata;
  rarst_pkg::out_t  res_q;

  logic [rarst_pkg::DataW-1:0] inc_q;
  logic [rarst_pkg::DataW-1:0] pend_q;
  logic [rarst_pkg::DataW-1:0] tmp_q;
  logic [rarst_pkg::DataW-1:0] prod_q;
  logic [rarst_pkg::DataW-1:0] acc_q;
  logic [rarst_pkg::DataW-1:0] addend;

  assign addend = cmd_i.use_pend ? pend_q : inc_q;

  // Build the node word to write
  always_comb begin
    unique case (cmd_i.wr_sel)
      rarst_pkg::WR_CLEAR: begin
        wdata = '0;
      end
      rarst_pkg::WR_COVER: begin
        wdata.total   = rdata_q.total + prod_q;
        wdata.pending = rdata_q.pending + addend;
      end
      rarst_pkg::WR_PEND_ZERO: begin
        wdata.total   = rdata_q.total;
        wdata.pending = '0;
      end
      rarst_pkg::WR_SUM: begin
        wdata.total   = tmp_q + rdata_q.total;
        wdata.pending = '0;
      end
      default: begin
        wdata = '0;
      end
    endcase
  end

  // Node memory: one port, registered read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.addr];
    end
  end

  // Data registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      inc_q <= $unsigned(in_data_i.increment);
    end
    if (cmd_i.cap_pend) begin
      pend_q <= rdata_q.pending;
    end
    if (cmd_i.cap_tmp) begin
      tmp_q <= rdata_q.total;
    end
    if (cmd_i.mul_go) begin
      prod_q <= rarst_pkg::DataW'(addend * rarst_pkg::DataW'(cmd_i.len));
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + rdata_q.total;
    end
    if (cmd_i.res_load) begin
      res_q.range_sum <= cmd_i.res_bad ? '0 : $signed(acc_q);
      res_q.bad_range <= cmd_i.res_bad;
    end
  end

  assign stat_o.pend_nz = (rdata_q.pending != '0);
  assign out_data_o     = res_q;

endmodule

// ===== src/rarst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rarst_ctrl
// Tree walk sequencer: return stack, node bounds, clearing sweep, handshakes.
// ----------------------------------------------------------------------------
module rarst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rarst_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [10:0]      cfg_data_i,
  input  rarst_pkg::stat_t stat_i,
  output rarst_pkg::cmd_t  cmd_o
);

  localparam int unsigned StackDepth = 16;
  localparam int unsigned SpW        = $clog2(StackDepth);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_ENTER,
    S_CV_RD, S_CV_MUL, S_CV_WR,
    S_SM_RD, S_SM_ACC,
    S_PD_RD, S_PD_CHK, S_PD_LRD, S_PD_LWR, S_PD_RRD, S_PD_RWR,
    S_RET, S_FX_RDL, S_FX_RDR, S_FX_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [rarst_pkg::NodeAw-1:0] idx;
    logic [rarst_pkg::LeafW-1:0]  lo;
    logic [rarst_pkg::LeafW-1:0]  hi;
  } frame_t;

  typedef struct packed {
    frame_t frame;
    logic   right;
  } entry_t;

  state_e  state_q;
  entry_t  stk_q [StackDepth];
  logic [SpW-1:0] sp_q;
  frame_t  cur_q;
  logic [9:0]  l_q;
  logic [10:0] r_q;
  logic        func_q;
  logic        bad_q;
  logic [10:0] size_q;
  logic [rarst_pkg::NodeAw-1:0] clr_q;
  logic        out_valid_q;

  logic [10:0] n_use;
  logic [rarst_pkg::LeafW-1:0] mid;
  logic [rarst_pkg::LeafW-1:0] top_mid;
  logic [rarst_pkg::NodeAw-1:0] left_idx;
  logic [rarst_pkg::NodeAw-1:0] right_idx;
  logic [rarst_pkg::LeafW:0] lohi_sum;
  logic [rarst_pkg::LeafW:0] top_sum;
  entry_t top;
  logic   outside;
  logic   covered;
  logic   res_take;
  logic   in_take;

  assign n_use = (size_q > 11'(rarst_pkg::MaxLeaves)) ? 11'(rarst_pkg::MaxLeaves) : size_q;

  // Node split points
  assign lohi_sum  = {1'b0, cur_q.lo} + {1'b0, cur_q.hi};
  assign mid       = lohi_sum[rarst_pkg::LeafW:1];
  assign left_idx  = {cur_q.idx[rarst_pkg::NodeAw-2:0], 1'b0};
  assign right_idx = {cur_q.idx[rarst_pkg::NodeAw-2:0], 1'b1};
  assign top       = stk_q[sp_q - SpW'(1)];
  assign top_sum   = {1'b0, top.frame.lo} + {1'b0, top.frame.hi};
  assign top_mid   = top_sum[rarst_pkg::LeafW:1];

  assign outside = (r_q <= cur_q.lo) || (cur_q.hi <= {1'b0, l_q});
  assign covered = ({1'b0, l_q} <= cur_q.lo) && (cur_q.hi <= r_q);

  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign in_take     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign res_take    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Decode datapath commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.wr_sel   = rarst_pkg::WR_CLEAR;
    cmd_o.addr     = cur_q.idx;
    cmd_o.res_load = res_take;
    cmd_o.res_bad  = bad_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.addr  = clr_q;
      end
      S_IDLE: begin
        cmd_o.acc_clr = 1'b1;
        cmd_o.load_in = 1'b1;
      end
      S_CV_RD, S_SM_RD, S_PD_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      S_CV_MUL: begin
        cmd_o.mul_go = 1'b1;
        cmd_o.len    = cur_q.hi - cur_q.lo;
      end
      S_CV_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = rarst_pkg::WR_COVER;
      end
      S_SM_ACC: begin
        cmd_o.acc_add = 1'b1;
      end
      S_PD_CHK: begin
        cmd_o.cap_pend = 1'b1;
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = rarst_pkg::WR_PEND_ZERO;
      end
      S_PD_LRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr     = left_idx;
        cmd_o.mul_go   = 1'b1;
        cmd_o.use_pend = 1'b1;
        cmd_o.len      = mid - cur_q.lo;
      end
      S_PD_LWR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.addr     = left_idx;
        cmd_o.wr_sel   = rarst_pkg::WR_COVER;
        cmd_o.use_pend = 1'b1;
      end
      S_PD_RRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr     = right_idx;
        cmd_o.mul_go   = 1'b1;
        cmd_o.use_pend = 1'b1;
        cmd_o.len      = cur_q.hi - mid;
      end
      S_PD_RWR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.addr     = right_idx;
        cmd_o.wr_sel   = rarst_pkg::WR_COVER;
        cmd_o.use_pend = 1'b1;
      end
      S_FX_RDL: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.addr  = left_idx;
      end
      S_FX_RDR: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.addr    = right_idx;
        cmd_o.cap_tmp = 1'b1;
      end
      S_FX_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = rarst_pkg::WR_SUM;
      end
      default: begin
        cmd_o.rd_en = 1'b0;
      end
    endcase
  end

  // State, stack and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      size_q      <= 11'(rarst_pkg::MaxLeaves);
      out_valid_q <= 1'b0;
      bad_q       <= 1'b0;
    end else begin
      // Raise the result word when loaded, drop it once taken
      if (res_take) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        size_q  <= cfg_data_i;
        clr_q   <= '0;
        state_q <= S_CLEAR;
      end else begin
        unique case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + 1'b1;
            if (clr_q == '1) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_take) begin
              l_q    <= in_data_i.left;
              r_q    <= in_data_i.right;
              func_q <= in_data_i.func;
              bad_q  <= (in_data_i.left >= in_data_i.right) ||
                        (in_data_i.right > n_use) || (n_use == '0);
              sp_q   <= '0;
              cur_q  <= '{idx: rarst_pkg::NodeAw'(1), lo: '0, hi: n_use};
              if ((in_data_i.left >= in_data_i.right) || (in_data_i.right > n_use)) begin
                state_q <= S_DONE;
              end else begin
                state_q <= S_ENTER;
              end
            end
          end
          S_ENTER: begin
            priority if (outside) begin
              state_q <= S_RET;
            end else if (covered) begin
              state_q <= func_q ? S_CV_RD : S_SM_RD;
            end else begin
              state_q <= S_PD_RD;
            end
          end
          S_CV_RD:  state_q <= S_CV_MUL;
          S_CV_MUL: state_q <= S_CV_WR;
          S_CV_WR:  state_q <= S_RET;
          S_SM_RD:  state_q <= S_SM_ACC;
          S_SM_ACC: state_q <= S_RET;
          S_PD_RD:  state_q <= S_PD_CHK;
          S_PD_CHK, S_PD_RWR: begin
            // Push the node and descend left once pending is settled
            if ((state_q == S_PD_CHK) && stat_i.pend_nz) begin
              state_q <= S_PD_LRD;
            end else begin
              stk_q[sp_q] <= '{frame: cur_q, right: 1'b0};
              sp_q        <= sp_q + 1'b1;
              cur_q       <= '{idx: left_idx, lo: cur_q.lo, hi: mid};
              state_q     <= S_ENTER;
            end
          end
          S_PD_LRD: state_q <= S_PD_LWR;
          S_PD_LWR: state_q <= S_PD_RRD;
          S_PD_RRD: state_q <= S_PD_RWR;
          S_RET: begin
            priority if (sp_q == '0) begin
              state_q <= S_DONE;
            end else if (!top.right) begin
              stk_q[sp_q - SpW'(1)].right <= 1'b1;
              cur_q <= '{idx: {top.frame.idx[rarst_pkg::NodeAw-2:0], 1'b1},
                         lo: top_mid, hi: top.frame.hi};
              state_q <= S_ENTER;
            end else begin
              sp_q    <= sp_q - 1'b1;
              cur_q   <= top.frame;
              state_q <= func_q ? S_FX_RDL : S_RET;
            end
          end
          S_FX_RDL: state_q <= S_FX_RDR;
          S_FX_RDR: state_q <= S_FX_WR;
          S_FX_WR:  state_q <= S_RET;
          S_DONE: begin
            if (res_take) begin
              state_q <= S_IDLE;
            end
          end
          default: state_q <= S_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== src/range_add_range_sum_tree_unit.sv =====
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_unit
// Range-add / range-sum store over up to 1024 signed 32-bit counters.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i/in_ready_o/in_data_i) takes one word per
//   operation: func 1 adds increment to every element of [left, right),
//   func 0 returns the wrapped sum of [left, right). Each word gives exactly
//   one result word on the output channel (out_valid_o/out_ready_i).
//   The config channel writes range_size; a write clears the whole store.
// Tree walk:
//   The walk is a lazy segment tree handled by a sequencer sharing a single
//   port node memory. Each visited node is skipped when outside the range,
//   read and accumulated (query) or read, scaled and written (update) when
//   covered, and split otherwise, with any pending value pushed down to both
//   children; an update also refreshes each split node's total on the way
//   back. A bad range skips the walk. One item is in flight at a time.
// Reset and stall:
//   After reset, and after each config write, a clearing sweep over all 4096
//   nodes runs while in_ready_o stays low. A result waits in the output
//   register while the receiver stalls; the next input word is still taken
//   and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rarst_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rarst_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [10:0]     cfg_data_i
);

  rarst_pkg::cmd_t  cmd;
  rarst_pkg::stat_t stat;

  // Sequencer
  rarst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Node store and arithmetic
  rarst_datapath u_datapath (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

// ===== src/rarst_checker.sv =====
// ----------------------------------------------------------------------------
// rarst_checker
// Port-level checks of the range-add / range-sum tree unit.
// ----------------------------------------------------------------------------
module rarst_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input rarst_pkg::out_t out_data_o,
  input logic            cfg_valid_i,
  input logic            cfg_ready_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // Flag a bad range with a zero sum
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_range |-> out_data_o.range_sum == '0)
    else $error("bad range word carries a nonzero sum");

  // Advance past idle after taking a word
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accepting a word");

  // Clear the store after a config write
  a_clear_after_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !in_ready_o)
    else $error("input ready right after a config write");

endmodule

bind range_add_range_sum_tree_unit rarst_checker u_rarst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
